// ===== hdl/csrspmv_pkg.sv =====
// Shared types and constants for the complex sparse matrix-vector multiply block.
package csrspmv_pkg;

  localparam int VECTOR_LEN_DEF = 1024;

  localparam int Q_DEPTH   = 4;
  localparam int Q_CW      = $clog2(Q_DEPTH) + 1;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CW    = $clog2(OUT_DEPTH) + 1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NONZERO = 2'd1,
    OP_EMPTY   = 2'd2
  } op_t;

  typedef struct packed {
    logic               emit;
    logic signed [23:0] a_re;
    logic signed [23:0] a_im;
    logic signed [23:0] x_re;
    logic signed [23:0] x_im;
  } work_t;

  typedef struct packed {
    logic signed [55:0] sum_re;
    logic signed [55:0] sum_im;
    logic [9:0]         row_number;
  } result_t;

endpackage

// ===== hdl/csrspmv_fifo.sv =====
// Small first-in first-out queue with occupancy count.
module csrspmv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count_next;

  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (wr_en && !rd_en) begin
      count_next = count + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule

// ===== hdl/csrspmv_front.sv =====
// Front end: accepts items, holds the dense vector store and fetches operands.
module csrspmv_front #(
  parameter int VECTOR_LEN = csrspmv_pkg::VECTOR_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 op,
  input  logic [9:0]                 position,
  input  logic signed [23:0]         value_re,
  input  logic signed [23:0]         value_im,
  input  logic                       row_end,
  input  logic [csrspmv_pkg::Q_CW-1:0] q_count,
  output logic                       work_valid,
  output csrspmv_pkg::work_t         work
);

  import csrspmv_pkg::*;

  localparam int AW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;

  logic [47:0]        vec_store [VECTOR_LEN];
  logic [AW-1:0]      addr;
  logic [16:0]        pos_ext;
  logic               in_range;
  logic               accept;
  logic [Q_CW:0]      q_used;

  logic               s1_valid;
  logic               s1_emit;
  logic               s1_hit;
  logic signed [23:0] s1_a_re;
  logic signed [23:0] s1_a_im;
  logic [47:0]        rd_data;

  assign pos_ext  = 17'(position);
  assign in_range = pos_ext < 17'(VECTOR_LEN);
  assign addr     = AW'(position);

  assign q_used = {1'b0, q_count} + (Q_CW + 1)'(s1_valid);
  assign full   = q_used >= (Q_CW + 1)'(Q_DEPTH);
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (accept && op == OP_LOAD && in_range) begin
      vec_store[addr] <= {value_re, value_im};
    end
    if (accept && op == OP_NONZERO && in_range) begin
      rd_data <= vec_store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit <= (op == OP_EMPTY) || (op == OP_NONZERO && row_end);
      s1_hit  <= (op == OP_NONZERO) && in_range;
      s1_a_re <= (op == OP_NONZERO) ? value_re : '0;
      s1_a_im <= (op == OP_NONZERO) ? value_im : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (op == OP_NONZERO || op == OP_EMPTY);
    end
  end

  assign work_valid = s1_valid;

  always_comb begin
    work.emit = s1_emit;
    work.a_re = s1_a_re;
    work.a_im = s1_a_im;
    work.x_re = s1_hit ? rd_data[47:24] : '0;
    work.x_im = s1_hit ? rd_data[23:0]  : '0;
  end

endmodule

// ===== hdl/csrspmv_back.sv =====
// Back end: pipelined complex multiply and saturating row accumulator.
module csrspmv_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  csrspmv_pkg::work_t             q_data,
  output logic                           q_pop,
  input  logic [csrspmv_pkg::OUT_CW-1:0] out_count,
  output logic                           res_push,
  output csrspmv_pkg::result_t           res
);

  import csrspmv_pkg::*;

  logic [OUT_CW:0]    inflight;

  logic               m_valid;
  logic               m_emit;
  logic signed [47:0] p_rr;
  logic signed [47:0] p_ii;
  logic signed [47:0] p_ri;
  logic signed [47:0] p_ir;

  logic               c_valid;
  logic               c_emit;
  logic signed [49:0] t_re;
  logic signed [49:0] t_im;

  logic signed [55:0] acc_re;
  logic signed [55:0] acc_im;
  logic [9:0]         row_count;
  logic signed [56:0] s_re;
  logic signed [56:0] s_im;
  logic signed [55:0] sat_re;
  logic signed [55:0] sat_im;

  assign inflight = (OUT_CW + 1)'(out_count) + (OUT_CW + 1)'(m_valid)
                  + (OUT_CW + 1)'(c_valid);
  assign q_pop    = !q_empty && (inflight < (OUT_CW + 1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_emit <= q_data.emit;
      p_rr   <= q_data.a_re * q_data.x_re;
      p_ii   <= q_data.a_im * q_data.x_im;
      p_ri   <= q_data.a_re * q_data.x_im;
      p_ir   <= q_data.a_im * q_data.x_re;
    end
    if (m_valid) begin
      c_emit <= m_emit;
      t_re   <= {{2{p_rr[47]}}, p_rr} - {{2{p_ii[47]}}, p_ii};
      t_im   <= {{2{p_ri[47]}}, p_ri} + {{2{p_ir[47]}}, p_ir};
    end
  end

  assign s_re = {acc_re[55], acc_re} + {{7{t_re[49]}}, t_re};
  assign s_im = {acc_im[55], acc_im} + {{7{t_im[49]}}, t_im};

  always_comb begin
    sat_re = s_re[55:0];
    if (s_re[56] != s_re[55]) begin
      sat_re = s_re[56] ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}};
    end
    sat_im = s_im[55:0];
    if (s_im[56] != s_im[55]) begin
      sat_im = s_im[56] ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}};
    end
  end

  assign res_push       = c_valid && c_emit;
  assign res.sum_re     = sat_re;
  assign res.sum_im     = sat_im;
  assign res.row_number = row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      c_valid   <= 1'b0;
      acc_re    <= '0;
      acc_im    <= '0;
      row_count <= '0;
    end else begin
      m_valid <= q_pop;
      c_valid <= m_valid;
      if (c_valid) begin
        if (c_emit) begin
          acc_re    <= '0;
          acc_im    <= '0;
          row_count <= row_count + 1'b1;
        end else begin
          acc_re <= sat_re;
          acc_im <= sat_im;
        end
      end
    end
  end

endmodule

// ===== hdl/complex_csr_spmv.sv =====
// Top level of the complex compressed-row sparse matrix-vector multiply block.
// A row-closing item passes the operand register, work queue, multiply and combine registers
// and output queue. Throughput: one item per cycle while full is low; the complex multiply
// is pipelined over two stages into a single accumulate register, and the vector store has
// one read and one write port. Reset clears the queues, accumulator and row counter; the
// vector store is not cleared and holds undefined data until loaded.
module complex_csr_spmv #(
  parameter int VECTOR_LEN = csrspmv_pkg::VECTOR_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         op,
  input  logic [9:0]         position,
  input  logic signed [23:0] value_re,
  input  logic signed [23:0] value_im,
  input  logic               row_end,
  output logic               empty,
  input  logic               pop,
  output logic signed [55:0] sum_re,
  output logic signed [55:0] sum_im,
  output logic [9:0]         row_number
);

  import csrspmv_pkg::*;

  logic              work_valid;
  work_t             work;
  logic [Q_CW-1:0]   q_count;
  logic              q_empty;
  logic              q_pop;
  logic [$bits(work_t)-1:0] q_bits;
  work_t             q_data;

  logic              res_push;
  result_t           res;
  logic [OUT_CW-1:0] out_count;
  logic [$bits(result_t)-1:0] out_bits;
  result_t           out_item;
  logic              out_pop;

  csrspmv_front #(
    .VECTOR_LEN(VECTOR_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .op        (op),
    .position  (position),
    .value_re  (value_re),
    .value_im  (value_im),
    .row_end   (row_end),
    .q_count   (q_count),
    .work_valid(work_valid),
    .work      (work)
  );

  csrspmv_fifo #(
    .WIDTH($bits(work_t)),
    .DEPTH(Q_DEPTH)
  ) u_work_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (work_valid),
    .wr_data(work),
    .rd_en  (q_pop),
    .rd_data(q_bits),
    .empty  (q_empty),
    .count  (q_count)
  );

  assign q_data = work_t'(q_bits);

  csrspmv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_count(out_count),
    .res_push (res_push),
    .res      (res)
  );

  assign out_pop = pop && !empty;

  csrspmv_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res),
    .rd_en  (out_pop),
    .rd_data(out_bits),
    .empty  (empty),
    .count  (out_count)
  );

  assign out_item   = result_t'(out_bits);
  assign sum_re     = out_item.sum_re;
  assign sum_im     = out_item.sum_im;
  assign row_number = out_item.row_number;

endmodule
